>>> hdl/acpf_pkg.sv
// ----------------------------------------------------------------------------
// acpf_pkg
// Shared types and fixed field widths of the rectangle pair collision filter.
// ----------------------------------------------------------------------------
package acpf_pkg;

   // fixed field widths
   localparam int SIZE_BITS    = 12;
   localparam int TYPE_BITS    = 3;
   localparam int TABLE_BITS   = 64;
   localparam int OUT_IDX_BITS = 4;
   localparam int RSP_W        = 16;

   // result token held in each cell
   typedef struct packed {
      logic hit;
      logic ne;
      logic nl;
   } acpf_tok_type;

   // sequencer commands to the cell row
   typedef struct packed {
      logic compare;
      logic shift;
   } acpf_ctl_type;

endpackage

>>> hdl/acpf_cell.sv
// ----------------------------------------------------------------------------
// acpf_cell
// One storage cell: holds one collider, tests it against the probe and
// passes its result token down the row toward the output end.
// ----------------------------------------------------------------------------
module acpf_cell
   import acpf_pkg::*;
#(
   parameter int CELL_ID    = 0,
   parameter int IDX_W      = 4,
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  acpf_ctl_type          ctl,
   input  logic [IDX_W-1:0]      probe_slot,
   input  logic [COORD_BITS-1:0] probe_x,
   input  logic [COORD_BITS-1:0] probe_y,
   input  logic [SIZE_BITS-1:0]  probe_w,
   input  logic [SIZE_BITS-1:0]  probe_h,
   input  logic [TYPE_BITS-1:0]  probe_type,
   input  logic                  probe_handler,
   input  logic [TABLE_BITS-1:0] notify_table,
   input  acpf_tok_type          tok_in,
   input  logic                  any_in,
   output acpf_tok_type          tok_out,
   output logic                  any_out
);

   localparam int EXT_W = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS + 1) + 1;

   // stored collider
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [SIZE_BITS-1:0]  w_ff, h_ff;
   logic [TYPE_BITS-1:0]  type_ff;
   logic                  handler_ff;
   acpf_tok_type          tok_ff, tok_next_in;

   logic                  is_target, is_valid;
   logic signed [EXT_W-1:0] ax, ay, ar, ab, bx, by, br, bb;
   logic                  overlap, ne, nl;

   assign is_target = (probe_slot == IDX_W'(CELL_ID));
   assign is_valid  = (IDX_W'(CELL_ID) < probe_slot);

   // exact edges, widened so nothing wraps
   assign ax = signed'({{(EXT_W-COORD_BITS){x_ff[COORD_BITS-1]}}, x_ff});
   assign ay = signed'({{(EXT_W-COORD_BITS){y_ff[COORD_BITS-1]}}, y_ff});
   assign bx = signed'({{(EXT_W-COORD_BITS){probe_x[COORD_BITS-1]}}, probe_x});
   assign by = signed'({{(EXT_W-COORD_BITS){probe_y[COORD_BITS-1]}}, probe_y});
   assign ar = ax + signed'({{(EXT_W-SIZE_BITS){1'b0}}, w_ff});
   assign ab = ay + signed'({{(EXT_W-SIZE_BITS){1'b0}}, h_ff});
   assign br = bx + signed'({{(EXT_W-SIZE_BITS){1'b0}}, probe_w});
   assign bb = by + signed'({{(EXT_W-SIZE_BITS){1'b0}}, probe_h});

   // strict overlap on both axes
   assign overlap = (ax < br) && (ar > bx) && (ay < bb) && (ab > by);

   // notify lookups for both sides
   assign ne = notify_table[{type_ff, probe_type}] && handler_ff;
   assign nl = notify_table[{probe_type, type_ff}] && probe_handler;

   // token next value
   always_comb begin
      tok_next_in = tok_ff;
      if (ctl.compare) begin
         tok_next_in.hit = is_valid && overlap && (ne || nl);
         tok_next_in.ne  = ne;
         tok_next_in.nl  = nl;
      end else if (ctl.shift) begin
         tok_next_in = tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_next_in;
      end
   end

   // store the probe in its slot
   always_ff @(posedge clock) begin
      if (ctl.compare && is_target) begin
         x_ff       <= probe_x;
         y_ff       <= probe_y;
         w_ff       <= probe_w;
         h_ff       <= probe_h;
         type_ff    <= probe_type;
         handler_ff <= probe_handler;
      end
   end

   assign tok_out = tok_ff;
   assign any_out = tok_ff.hit || any_in;

endmodule

>>> hdl/aabb_pair_collision_filter.sv
// ----------------------------------------------------------------------------
// aabb_pair_collision_filter
// Tests each arriving rectangle against the colliders stored this frame
// and streams out one beat per notified colliding pair.
// ----------------------------------------------------------------------------
// One collider is handled at a time. After a beat is taken the new rectangle
// is compared against all stored colliders at once (one cell per slot),
// then the hit tokens shift through the cell row toward the output, one cell
// per cycle, pausing while a hit at the output end waits on the result side,
// until no hit remains. A full store drops the collider and sets the overflow
// flag. The output register lets the last result wait while the next beat is
// accepted.
module aabb_pair_collision_filter
   import acpf_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [TABLE_BITS-1:0] csr_wr_data,
   // input beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, width, height, kind, has_handler, zero fill
   input  logic [((2*COORD_BITS+2*SIZE_BITS+TYPE_BITS+1+7)/8)*8-1:0] req_tdata,
   // new_frame
   input  logic                  req_tuser,
   // result beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // earlier_index, later_index, notify_earlier, notify_later, overflowed, zero fill
   output logic [RSP_W-1:0]      rsp_tdata,
   // last_of_run
   output logic                  rsp_tlast
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam int OFS_Y = COORD_BITS;
   localparam int OFS_W = 2 * COORD_BITS;
   localparam int OFS_H = OFS_W + SIZE_BITS;
   localparam int OFS_T = OFS_H + SIZE_BITS;
   localparam int OFS_E = OFS_T + TYPE_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [TABLE_BITS-1:0] table_ff;

   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [SIZE_BITS-1:0]  pw_ff, ph_ff;
   logic [TYPE_BITS-1:0]  pt_ff;
   logic                  phd_ff;
   logic [IDX_W-1:0]      slot_ff;
   logic                  run_ovf_ff;
   logic [IDX_W-1:0]      head_ff, head_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff;
   logic                  rsp_last_ff;

   logic                  req_fire, full, out_free, rsp_load;
   logic [CNT_W-1:0]      eff_count;
   logic                  eff_ovf;
   acpf_ctl_type          ctl;
   acpf_tok_type          tok_c [SLOTS+1];
   logic [SLOTS:0]        any_c;
   logic [IDX_W+OUT_IDX_BITS-1:0] early_ext, late_ext;
   logic [RSP_W-1:0]      rsp_data_in;

   // input handshake and frame restart
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign eff_count  = req_tuser ? '0 : count_ff;
   assign eff_ovf    = req_tuser ? 1'b0 : ovf_ff;
   assign full       = (eff_count >= CNT_W'(SLOTS));

   // output register can take a new beat
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      head_in      = head_ff;
      ctl          = '0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in = eff_count;
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ovf_in   = eff_ovf;
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            ctl.compare = 1'b1;
            count_in    = count_ff + CNT_W'(1);
            head_in     = '0;
            state_in    = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (!any_c[0]) begin
               state_in = ST_IDLE;
            end else if (!tok_c[0].hit || out_free) begin
               rsp_load  = tok_c[0].hit;
               ctl.shift = 1'b1;
               head_in   = head_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         table_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (csr_wr_en) begin
            table_ff <= csr_wr_data;
         end
      end
   end

   // probe capture
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      if (req_fire && !full) begin
         px_ff      <= req_tdata[OFS_Y-1:0];
         py_ff      <= req_tdata[OFS_W-1:OFS_Y];
         pw_ff      <= req_tdata[OFS_H-1:OFS_W];
         ph_ff      <= req_tdata[OFS_T-1:OFS_H];
         pt_ff      <= req_tdata[OFS_E-1:OFS_T];
         phd_ff     <= req_tdata[OFS_E];
         slot_ff    <= eff_count[IDX_W-1:0];
         run_ovf_ff <= eff_ovf;
      end
   end

   // cell row, output end at cell zero
   assign tok_c[SLOTS] = '0;
   assign any_c[SLOTS] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      acpf_cell #(
         .CELL_ID   (i),
         .IDX_W     (IDX_W),
         .COORD_BITS(COORD_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .probe_slot   (slot_ff),
         .probe_x      (px_ff),
         .probe_y      (py_ff),
         .probe_w      (pw_ff),
         .probe_h      (ph_ff),
         .probe_type   (pt_ff),
         .probe_handler(phd_ff),
         .notify_table (table_ff),
         .tok_in       (tok_c[i+1]),
         .any_in       (any_c[i+1]),
         .tok_out      (tok_c[i]),
         .any_out      (any_c[i])
      );
   end

   // result beat assembly
   assign early_ext   = {{OUT_IDX_BITS{1'b0}}, head_ff};
   assign late_ext    = {{OUT_IDX_BITS{1'b0}}, slot_ff};
   assign rsp_data_in = {{(RSP_W-2*OUT_IDX_BITS-3){1'b0}}, run_ovf_ff,
                         tok_c[0].nl, tok_c[0].ne,
                         late_ext[OUT_IDX_BITS-1:0], early_ext[OUT_IDX_BITS-1:0]};

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= !any_c[1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("stored count beyond capacity");

   a_idle_no_hits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !any_c[0])
      else $error("hit tokens left in the row while idle");

   a_cmp_appends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("compare pass did not append the collider");

endmodule
